// File: hdl/rrss_pkg.sv
// Shared constants for the round-robin slice scheduler.
// Used by the top level, the shared arithmetic unit, the checker and the bench; no dependencies.
package rrss_pkg;

   localparam int DEF_MAX_PROCS  = 16;
   localparam int DEF_TIME_WIDTH = 16;

   localparam int BURST_W = 16;
   localparam int QUANT_W = 16;
   localparam int SLICE_W = 16;
   localparam int PN_W    = 5;
   localparam int CLK_W   = 20;

   localparam logic [CLK_W-1:0]   CLOCK_MAX     = {CLK_W{1'b1}};
   localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(4);

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   typedef logic alu_op_type;
   localparam alu_op_type ALU_ADD = 1'b0;
   localparam alu_op_type ALU_SUB = 1'b1;

endpackage

// File: hdl/round_robin_slice_scheduler.sv
// Round-robin slice scheduler. A load request gives no result.
// An advance request scans table entries (1 to process count) at one per cycle,
// then clamps the slice to the quantum and updates the clock, and on completion works
// out the waiting time; the strobe comes in the cycle after the last step, when start is taken again.
// With nothing to run the strobe comes after the scan, or in the next cycle if empty.
// Synchronous reset clears the sequencer, counters and clock, sets the quantum to 4.
module round_robin_slice_scheduler #(
   parameter int MAX_PROCS  = rrss_pkg::DEF_MAX_PROCS,
   parameter int TIME_WIDTH = rrss_pkg::DEF_TIME_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [rrss_pkg::BURST_W-1:0]  req_burst_time,
   output logic                          rsp_strobe,
   output logic [rrss_pkg::PN_W-1:0]     rsp_process_number,
   output logic [rrss_pkg::SLICE_W-1:0]  rsp_slice_length,
   output logic [rrss_pkg::CLK_W-1:0]    rsp_slice_end_time,
   output logic                          rsp_finished,
   output logic [rrss_pkg::CLK_W-1:0]    rsp_waiting_time,
   output logic [rrss_pkg::CLK_W-1:0]    rsp_turnaround_time,
   output logic                          rsp_all_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rrss_pkg::QUANT_W-1:0]  csr_wdata
);
   import rrss_pkg::*;

   localparam int TW    = TIME_WIDTH;
   localparam int IW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW    = $clog2(MAX_PROCS + 1);
   localparam int AW    = ((TW > CLK_W) ? TW : CLK_W) + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MIN  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [QUANT_W-1:0] quantum_ff, quantum_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      cursor_ff, cursor_in;
   logic [CLK_W-1:0]   clock_ff, clock_in;
   logic               running_ff, running_in;
   logic [IW-1:0]      scan_idx_ff, scan_idx_in;
   logic [IW-1:0]      k_ff, k_in;
   logic [TW-1:0]      rem_ff, rem_in;
   logic [TW-1:0]      burst_ff, burst_in;
   logic [SLICE_W-1:0] run_ff, run_in;
   logic [TW-1:0]      newrem_ff, newrem_in;

   logic               strobe_ff, strobe_in;
   logic [PN_W-1:0]    pn_ff, pn_in;
   logic [SLICE_W-1:0] len_ff, len_in;
   logic [CLK_W-1:0]   end_ff, end_in;
   logic               fin_ff, fin_in;
   logic [CLK_W-1:0]   wt_ff, wt_in;
   logic [CLK_W-1:0]   tat_ff, tat_in;
   logic               done_ff, done_in;

   logic               accept;
   logic               load_ok;
   logic [QUANT_W-1:0] q_eff;
   logic [CW-1:0]      idx_next;
   logic [IW-1:0]      idx_wrap;
   logic               scan_last;
   logic [CLK_W-1:0]   clock_sat;
   logic [PN_W-1:0]    pn_cur;

   alu_op_type         alu_op;
   logic [AW-1:0]      alu_a, alu_b, alu_res;
   logic               alu_borrow;

   logic               rem_we;
   logic [IW-1:0]      rem_waddr;
   logic [TW-1:0]      rem_wdata;
   logic [TW-1:0]      rem_rdata, burst_rdata;

   rrss_alu #(.AW(AW)) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   rrss_table #(.DEPTH(MAX_PROCS), .TW(TW), .IW(IW)) u_table (
      .clock       (clock),
      .rem_we      (rem_we),
      .rem_waddr   (rem_waddr),
      .rem_wdata   (rem_wdata),
      .burst_we    (load_ok),
      .burst_waddr (count_ff[IW-1:0]),
      .burst_wdata (TW'(req_burst_time)),
      .raddr       (scan_idx_in),
      .rem_rdata   (rem_rdata),
      .burst_rdata (burst_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign load_ok   = accept && (req_mode == MODE_LOAD) && !running_ff
                      && (count_ff < CW'(MAX_PROCS));
   assign q_eff     = (quantum_ff == '0) ? QUANT_W'(1) : quantum_ff;
   assign idx_next  = CW'(scan_idx_ff) + CW'(1);
   assign idx_wrap  = (idx_next == count_ff) ? '0 : idx_next[IW-1:0];
   assign scan_last = ((CW'(k_ff) + CW'(1)) == count_ff);
   assign clock_sat = (|alu_res[AW-1:CLK_W]) ? CLOCK_MAX : alu_res[CLK_W-1:0];
   assign pn_cur    = PN_W'(idx_next);

   assign rem_we    = load_ok || (state_ff == ST_ADD);
   assign rem_waddr = (state_ff == ST_ADD) ? scan_idx_ff : count_ff[IW-1:0];
   assign rem_wdata = (state_ff == ST_ADD) ? newrem_ff : TW'(req_burst_time);

   // Shared unit operands per sequencer step
   always_comb begin
      case (state_ff)
         ST_SCAN: begin
            alu_op = ALU_SUB;
            alu_a  = '0;
            alu_b  = AW'(rem_rdata);
         end
         ST_MIN: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(rem_ff);
            alu_b  = AW'(q_eff);
         end
         ST_ADD: begin
            alu_op = ALU_ADD;
            alu_a  = AW'(clock_ff);
            alu_b  = AW'(run_ff);
         end
         ST_WAIT: begin
            alu_op = ALU_SUB;
            alu_a  = AW'(clock_ff);
            alu_b  = AW'(burst_ff);
         end
         default: begin
            alu_op = ALU_ADD;
            alu_a  = '0;
            alu_b  = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      quantum_in  = quantum_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      clock_in    = clock_ff;
      running_in  = running_ff;
      scan_idx_in = scan_idx_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      burst_in    = burst_ff;
      run_in      = run_ff;
      newrem_in   = newrem_ff;
      strobe_in   = 1'b0;
      pn_in       = pn_ff;
      len_in      = len_ff;
      end_in      = end_ff;
      fin_in      = fin_ff;
      wt_in       = wt_ff;
      tat_in      = tat_ff;
      done_in     = done_ff;

      if (csr_valid && csr_ready) begin
         quantum_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (load_ok) begin
               count_in = count_ff + CW'(1);
            end
            if (accept && (req_mode == MODE_ADVANCE)) begin
               running_in = 1'b1;
               if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  pn_in     = '0;
                  len_in    = '0;
                  end_in    = clock_ff;
                  fin_in    = 1'b0;
                  wt_in     = '0;
                  tat_in    = '0;
                  done_in   = 1'b1;
               end else begin
                  scan_idx_in = cursor_ff;
                  k_in        = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // borrow of 0 - remaining marks an entry with work left
            if (alu_borrow) begin
               rem_in   = rem_rdata;
               burst_in = burst_rdata;
               state_in = ST_MIN;
            end else if (scan_last) begin
               strobe_in = 1'b1;
               pn_in     = '0;
               len_in    = '0;
               end_in    = clock_ff;
               fin_in    = 1'b0;
               wt_in     = '0;
               tat_in    = '0;
               done_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               scan_idx_in = idx_wrap;
               k_in        = k_ff + IW'(1);
            end
         end
         ST_MIN: begin
            if (alu_borrow) begin
               run_in    = SLICE_W'(rem_ff);
               newrem_in = '0;
            end else begin
               run_in    = q_eff;
               newrem_in = alu_res[TW-1:0];
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            clock_in  = clock_sat;
            cursor_in = idx_wrap;
            pn_in     = pn_cur;
            len_in    = run_ff;
            end_in    = clock_sat;
            done_in   = 1'b0;
            if (newrem_ff == '0) begin
               state_in = ST_WAIT;
            end else begin
               strobe_in = 1'b1;
               fin_in    = 1'b0;
               wt_in     = '0;
               tat_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         ST_WAIT: begin
            // floor waiting time at zero when the clock has saturated
            strobe_in = 1'b1;
            fin_in    = 1'b1;
            wt_in     = alu_borrow ? '0 : alu_res[CLK_W-1:0];
            tat_in    = clock_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         quantum_ff <= QUANTUM_RESET;
         count_ff   <= '0;
         cursor_ff  <= '0;
         clock_ff   <= '0;
         running_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         quantum_ff <= quantum_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         clock_ff   <= clock_in;
         running_ff <= running_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      burst_ff    <= burst_in;
      run_ff      <= run_in;
      newrem_ff   <= newrem_in;
      pn_ff       <= pn_in;
      len_ff      <= len_in;
      end_ff      <= end_in;
      fin_ff      <= fin_in;
      wt_ff       <= wt_in;
      tat_ff      <= tat_in;
      done_ff     <= done_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_process_number  = pn_ff;
   assign rsp_slice_length    = len_ff;
   assign rsp_slice_end_time  = end_ff;
   assign rsp_finished        = fin_ff;
   assign rsp_waiting_time    = wt_ff;
   assign rsp_turnaround_time = tat_ff;
   assign rsp_all_done        = done_ff;

endmodule

// File: hdl/rrss_alu.sv
// Shared add/subtract unit of the scheduler; the sequencer reuses it for
// the work scan, the quantum clamp, the clock update and the waiting time.
// Depends on rrss_pkg.
module rrss_alu #(
   parameter int AW = 33
) (
   input  rrss_pkg::alu_op_type op,
   input  logic [AW-1:0]        a,
   input  logic [AW-1:0]        b,
   output logic [AW-1:0]        res,
   output logic                 borrow
);
   import rrss_pkg::*;

   logic [AW:0] diff;

   assign diff = {1'b0, a} - {1'b0, b};

   always_comb begin
      case (op)
         ALU_SUB: begin
            res    = diff[AW-1:0];
            borrow = diff[AW];
         end
         default: begin
            res    = a + b;
            borrow = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/rrss_table.sv
// Burst and remaining-time tables: one write port each, one shared
// read address with registered read data. Depends on nothing but its parameters.
module rrss_table #(
   parameter int DEPTH = 16,
   parameter int TW    = 16,
   parameter int IW    = 4
) (
   input  logic          clock,
   input  logic          rem_we,
   input  logic [IW-1:0] rem_waddr,
   input  logic [TW-1:0] rem_wdata,
   input  logic          burst_we,
   input  logic [IW-1:0] burst_waddr,
   input  logic [TW-1:0] burst_wdata,
   input  logic [IW-1:0] raddr,
   output logic [TW-1:0] rem_rdata,
   output logic [TW-1:0] burst_rdata
);

   logic [TW-1:0] rem_mem   [DEPTH];
   logic [TW-1:0] burst_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[rem_waddr] <= rem_wdata;
      end
      rem_rdata <= rem_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (burst_we) begin
         burst_mem[burst_waddr] <= burst_wdata;
      end
      burst_rdata <= burst_mem[raddr];
   end

endmodule

// File: hdl/rrss_checker.sv
// Port-level checks for the round-robin slice scheduler, bound to its top level.
// Depends on rrss_pkg and round_robin_slice_scheduler.
module rrss_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_mode,
   input  logic                          rsp_strobe,
   input  logic [rrss_pkg::PN_W-1:0]     rsp_process_number,
   input  logic [rrss_pkg::SLICE_W-1:0]  rsp_slice_length,
   input  logic [rrss_pkg::CLK_W-1:0]    rsp_slice_end_time,
   input  logic                          rsp_finished,
   input  logic [rrss_pkg::CLK_W-1:0]    rsp_waiting_time,
   input  logic [rrss_pkg::CLK_W-1:0]    rsp_turnaround_time,
   input  logic                          rsp_all_done
);
   import rrss_pkg::*;

   a_advance_works: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_ADVANCE) |=> (busy || rsp_strobe))
      else $error("advance request produced neither work nor result");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_LOAD) |=> (!busy && !rsp_strobe))
      else $error("load request produced a result or busy cycle");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_all_done) |->
         (rsp_process_number == '0 && rsp_slice_length == '0 && !rsp_finished))
      else $error("all-done result carries slice data");

   a_running_times: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_finished) |->
         (rsp_waiting_time == '0 && rsp_turnaround_time == '0))
      else $error("unfinished slice carries completion times");

   a_finish_times: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_finished) |->
         (rsp_turnaround_time == rsp_slice_end_time
          && rsp_waiting_time <= rsp_turnaround_time && !rsp_all_done))
      else $error("completion times inconsistent");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_mode            (req_mode),
   .rsp_strobe          (rsp_strobe),
   .rsp_process_number  (rsp_process_number),
   .rsp_slice_length    (rsp_slice_length),
   .rsp_slice_end_time  (rsp_slice_end_time),
   .rsp_finished        (rsp_finished),
   .rsp_waiting_time    (rsp_waiting_time),
   .rsp_turnaround_time (rsp_turnaround_time),
   .rsp_all_done        (rsp_all_done)
);

// File: tb/tb_round_robin_slice_scheduler.sv
// Self-checking bench for round_robin_slice_scheduler: a directed table, then random phases.
// Depends on rrss_pkg and the scheduler RTL. The bench keeps its own copy of the process
// table and clock and uses it to predict each slice.
module tb_round_robin_slice_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import rrss_pkg::*;

   localparam int NPROC       = DEF_MAX_PROCS;
   localparam int SETTLE      = NPROC + 8;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [PN_W-1:0]    pnum;
      logic [SLICE_W-1:0] length;
      logic [CLK_W-1:0]   stop_time;
      logic               finished;
      logic [CLK_W-1:0]   wait_time;
      logic [CLK_W-1:0]   turnaround;
      logic               all_done;
   } slice_type;

   typedef struct {
      logic               mode;
      logic [BURST_W-1:0] burst;
      bit                 typed;
      slice_type          want;
   } stim_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic               req_mode       = MODE_LOAD;
   logic [BURST_W-1:0] req_burst_time = '0;
   logic               rsp_strobe;
   logic [PN_W-1:0]    rsp_process_number;
   logic [SLICE_W-1:0] rsp_slice_length;
   logic [CLK_W-1:0]   rsp_slice_end_time;
   logic               rsp_finished;
   logic [CLK_W-1:0]   rsp_waiting_time;
   logic [CLK_W-1:0]   rsp_turnaround_time;
   logic               rsp_all_done;
   logic               csr_valid      = 1'b0;
   logic               csr_ready;
   logic [QUANT_W-1:0] csr_wdata      = '0;

   // scheduler copy kept by the bench
   logic [BURST_W-1:0] burst_mem [NPROC];
   logic [BURST_W-1:0] left_mem  [NPROC];
   int unsigned        loaded        = 0;
   int unsigned        cursor        = 0;
   logic [CLK_W-1:0]   now           = '0;
   bit                 started       = 1'b0;
   logic [QUANT_W-1:0] slice_quantum = QUANTUM_RESET;

   slice_type          due_slices [$];
   stim_row_type       dir_rows [$];
   int unsigned        errors        = 0;
   int unsigned        cycles        = 0;
   int unsigned        steady_left   = 0;
   int unsigned        n_loads       = 0;
   int unsigned        n_advances    = 0;
   int unsigned        n_results     = 0;
   int unsigned        n_finished    = 0;
   int unsigned        n_idle        = 0;

   round_robin_slice_scheduler i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_burst_time     (req_burst_time),
      .rsp_strobe         (rsp_strobe),
      .rsp_process_number (rsp_process_number),
      .rsp_slice_length   (rsp_slice_length),
      .rsp_slice_end_time (rsp_slice_end_time),
      .rsp_finished       (rsp_finished),
      .rsp_waiting_time   (rsp_waiting_time),
      .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_all_done       (rsp_all_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one request to the bench copy; returns 1 when the request yields a slice.
   function automatic bit schedule_next(input logic mode, input logic [BURST_W-1:0] burst,
                                        output slice_type res);
      int unsigned     pick;
      int unsigned     slot;
      int unsigned     limit;
      int unsigned     grant;
      bit              hit;
      longint unsigned total;
      res = '0;
      if (mode == MODE_LOAD) begin
         // drop loads once scheduling has begun or the table is full
         if (!started && loaded < NPROC) begin
            burst_mem[loaded] = burst;
            left_mem[loaded]  = burst;
            loaded++;
         end
         return 1'b0;
      end
      started = 1'b1;
      hit     = 1'b0;
      pick    = 0;
      for (int k = 0; k < loaded && !hit; k++) begin
         slot = (cursor + k) % loaded;
         if (left_mem[slot] != 0) begin
            pick = slot;
            hit  = 1'b1;
         end
      end
      if (!hit) begin
         res.stop_time = now;
         res.all_done  = 1'b1;
         return 1'b1;
      end
      limit          = (slice_quantum == 0) ? 1 : slice_quantum;
      grant          = (left_mem[pick] > limit) ? limit : left_mem[pick];
      left_mem[pick] = left_mem[pick] - BURST_W'(grant);
      total          = longint'(now) + grant;
      now            = (total > CLOCK_MAX) ? CLOCK_MAX : CLK_W'(total);
      cursor         = (pick + 1 >= loaded) ? 0 : pick + 1;
      res.pnum       = PN_W'(pick + 1);
      res.length     = SLICE_W'(grant);
      res.stop_time  = now;
      if (left_mem[pick] == 0) begin
         res.finished   = 1'b1;
         res.wait_time  = (now >= burst_mem[pick]) ? now - burst_mem[pick] : '0;
         res.turnaround = now;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [CLK_W-1:0] got,
                              input logic [CLK_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("slice %0d %s got %0d want %0d", n_results, name, got, want));
   endtask

   // Present one request after a random gap and hold it until the block takes it.
   task automatic send_request(input logic mode, input logic [BURST_W-1:0] burst,
                               input bit typed, input slice_type want);
      int unsigned gap;
      slice_type   calc;
      if (steady_left > 0) begin
         gap = 0;
         steady_left--;
      end else begin
         gap = $urandom_range(0, 16);
         if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_burst_time <= burst;
      do @(posedge clock); while (busy);
      if (schedule_next(mode, burst, calc)) due_slices.push_back(typed ? want : calc);
      if (mode == MODE_LOAD) n_loads++;
      else n_advances++;
   endtask

   // Let every outstanding slice arrive, then allow for a scan still in flight.
   task automatic drain;
      start <= 1'b0;
      while (due_slices.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [QUANT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      slice_quantum = value;
   endtask

   always @(posedge clock) begin : watch
      slice_type want;
      if (!reset && rsp_strobe) begin
         if (due_slices.size() == 0) begin
            report_mismatch("slice reported with none outstanding");
         end else begin
            want = due_slices.pop_front();
            check_field("process_number", CLK_W'(rsp_process_number), CLK_W'(want.pnum));
            check_field("slice_length", CLK_W'(rsp_slice_length), CLK_W'(want.length));
            check_field("slice_end_time", rsp_slice_end_time, want.stop_time);
            check_field("finished", CLK_W'(rsp_finished), CLK_W'(want.finished));
            check_field("waiting_time", rsp_waiting_time, want.wait_time);
            check_field("turnaround_time", rsp_turnaround_time, want.turnaround);
            check_field("all_done", CLK_W'(rsp_all_done), CLK_W'(want.all_done));
         end
         n_results++;
         if (rsp_finished === 1'b1) n_finished++;
         if (rsp_all_done === 1'b1) n_idle++;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout at cycle %0d with %0d slices outstanding", cycles, due_slices.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [BURST_W-1:0] load_bursts [NPROC+1];
      logic [QUANT_W-1:0] q;
      int unsigned        counted;
      load_bursts = '{16'hFFFF, 16'h0000, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFE,
                      16'd100, 16'd37, 16'h8000, 16'd7, 16'd300, 16'd1000, 16'd12, 16'd9,
                      16'h5555};
      // fill the table; the last load is one beyond capacity and gets dropped
      foreach (load_bursts[i]) dir_rows.push_back('{MODE_LOAD, load_bursts[i], 1'b0, '0});
      // first slice at the reset quantum
      dir_rows.push_back('{MODE_ADVANCE, 16'h0000, 1'b1,
                           slice_type'{5'd1, 16'd4, 20'd4, 1'b0, 20'd0, 20'd0, 1'b0}});
      dir_rows.push_back('{MODE_LOAD, 16'd1, 1'b0, '0});
      // zero-burst process is skipped, the one-unit process completes
      dir_rows.push_back('{MODE_ADVANCE, 16'hFFFF, 1'b1,
                           slice_type'{5'd3, 16'd1, 20'd5, 1'b1, 20'd4, 20'd5, 1'b0}});
      repeat (3) dir_rows.push_back('{MODE_ADVANCE, 16'h0000, 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].mode, dir_rows[i].burst, dir_rows[i].typed, dir_rows[i].want);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: q = '0;
            1: q = QUANT_W'(1);
            2: q = QUANT_W'($urandom_range(2, 64));
            3: q = QUANT_W'(2);
            4: q = QUANT_W'($urandom_range(65, 4096));
            5: q = QUANT_W'($urandom_range(4097, 65534));
            6: q = '1;
            default: q = QUANTUM_RESET;
         endcase
         write_quantum(q);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // a stray load now and then; the block must drop it
            if ($urandom_range(0, 9) == 0) begin
               send_request(MODE_LOAD, BURST_W'($urandom), 1'b0, '0);
            end else begin
               send_request(MODE_ADVANCE, BURST_W'($urandom), 1'b0, '0);
            end
            counted++;
         end
         drain();
      end

      $display("Ran %0d loads and %0d advances across %0d quantum settings, zero through max",
               n_loads, n_advances, PHASES + 1);
      $display("Checked %0d slices: %0d completions, %0d idle, final clock %0d",
               n_results, n_finished, n_idle, now);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
